// ===== src/mandelbrot_escape_time_defines.svh =====
// Assertion macros for the asserting file.
`ifndef MANDELBROT_ESCAPE_TIME_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define MBE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define MBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/mbe_pkg.sv =====
package mbe_pkg;

	// Fixed field widths
	localparam int C_WIDTH         = 31;
	localparam int LIMIT_WIDTH     = 16;
	localparam int COUNT_OUT_WIDTH = 16;

	// Fraction bits of the Q format
	localparam int FRAC_BITS = 28;

	// Defaults for the top-level parameters and the limit register
	localparam int                     DEF_VALUE_WIDTH = 32;
	localparam int                     DEF_COUNT_WIDTH = 16;
	localparam logic [LIMIT_WIDTH-1:0] DEF_ITER_LIMIT  = 16'd1000;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_RE,
		S_MUL_IM,
		S_MUL_X,
		S_UPDATE,
		S_DONE
	} state_t;

	// Operand pair for the shared multiplier
	typedef enum logic [1:0] {
		MUL_RR,
		MUL_II,
		MUL_RI
	} mul_sel_t;

	// Sequencer to datapath controls
	typedef struct packed {
		logic     start;
		mul_sel_t mul_sel;
		logic     cap_sr;
		logic     cap_si;
		logic     update;
	} dp_ctrl_t;

endpackage

// ===== src/mbe_in_if.sv =====
interface mbe_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [mbe_pkg::C_WIDTH-1:0]  c_real;
	logic signed [mbe_pkg::C_WIDTH-1:0]  c_imag;

	modport source (output valid, output c_real, output c_imag, input ready);
	modport sink (input valid, input c_real, input c_imag, output ready);
endinterface

// ===== src/mbe_out_if.sv =====
interface mbe_out_if;
	logic                                  valid;
	logic                                  ready;
	logic [mbe_pkg::COUNT_OUT_WIDTH-1:0]   iteration_count;
	logic                                  reached_limit;

	modport source (output valid, output iteration_count, output reached_limit, input ready);
	modport sink (input valid, input iteration_count, input reached_limit, output ready);
endinterface

// ===== src/mbe_datapath.sv =====
module mbe_datapath #(
	parameter int VALUE_WIDTH = mbe_pkg::DEF_VALUE_WIDTH
) (
	input  logic                               clk,
	input  mbe_pkg::dp_ctrl_t                  ctrl,
	input  logic signed [mbe_pkg::C_WIDTH-1:0] c_real,
	input  logic signed [mbe_pkg::C_WIDTH-1:0] c_imag,
	output logic                               escape
);
	import mbe_pkg::*;

	localparam int PW = 2 * VALUE_WIDTH;
	localparam logic signed [PW:0] ESC_BOUND = (PW+1)'(1) << (FRAC_BITS + 2);

	logic signed [VALUE_WIDTH-1:0] z_re_q, z_im_q;
	logic signed [C_WIDTH-1:0]     c_re_q, c_im_q;
	logic signed [VALUE_WIDTH-1:0] mul_a, mul_b;
	logic signed [PW-1:0]          prod_d, prod_q;
	logic signed [PW-1:0]          sq_d, cross_d;
	logic signed [PW-1:0]          sr_q, si_q;
	logic signed [PW-1:0]          c_re_ext, c_im_ext;
	logic signed [PW-1:0]          nre, nim;
	logic signed [PW:0]            sq_sum;

	// Pick operands for the shared multiplier
	always_comb begin
		unique case (ctrl.mul_sel)
			MUL_RR: begin
				mul_a = z_re_q;
				mul_b = z_re_q;
			end
			MUL_II: begin
				mul_a = z_im_q;
				mul_b = z_im_q;
			end
			MUL_RI: begin
				mul_a = z_re_q;
				mul_b = z_im_q;
			end
			default: begin
				mul_a = z_re_q;
				mul_b = z_re_q;
			end
		endcase
	end

	assign prod_d = PW'(mul_a) * PW'(mul_b);

	// Floor shifts of the registered product
	assign sq_d    = prod_q >>> FRAC_BITS;
	assign cross_d = prod_q >>> (FRAC_BITS - 1);

	// Escape test on the square sum, one bit wider than the product
	assign sq_sum = {sr_q[PW-1], sr_q} + {sq_d[PW-1], sq_d};
	assign escape = sq_sum > ESC_BOUND;

	// Next z, wrapped to the value width
	assign c_re_ext = PW'(c_re_q);
	assign c_im_ext = PW'(c_im_q);
	assign nre      = sr_q - si_q + c_re_ext;
	assign nim      = cross_d + c_im_ext;

	// Hold c and z, capture squares, advance z
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		if (ctrl.cap_sr) begin
			sr_q <= sq_d;
		end
		if (ctrl.cap_si) begin
			si_q <= sq_d;
		end
		if (ctrl.start) begin
			c_re_q <= c_real;
			c_im_q <= c_imag;
			z_re_q <= '0;
			z_im_q <= '0;
		end else if (ctrl.update) begin
			z_re_q <= nre[VALUE_WIDTH-1:0];
			z_im_q <= nim[VALUE_WIDTH-1:0];
		end
	end
endmodule

// ===== src/mandelbrot_escape_time.sv =====
// Mandelbrot escape-time unit. Each input beat carries one point c (signed Q3.28
// real and imaginary parts); the unit iterates z = z*z + c from z = 0 and returns
// one beat with the iteration count and a flag that is set when the count reached
// the limit register (reset value 1000) rather than |z|^2 exceeding 4.0. A single
// multiplier is shared by the three products of an iteration, so the sequencer
// steps through S_MUL_RE, S_MUL_IM, S_MUL_X and S_UPDATE for each iteration. The
// input is not ready while a point is in progress and becomes ready in the cycle
// the result beat appears; a finished result waits in the output register while
// the next point is accepted, and a point that finishes while that register is
// still full waits until it is taken. A limit of zero returns a count of zero
// with the flag set. Write the limit only while the unit is idle.
`include "mandelbrot_escape_time_defines.svh"

module mandelbrot_escape_time #(
	parameter int VALUE_WIDTH = mbe_pkg::DEF_VALUE_WIDTH,
	parameter int COUNT_WIDTH = mbe_pkg::DEF_COUNT_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 limit_we,
	input  logic [mbe_pkg::LIMIT_WIDTH-1:0]      limit_wdata,
	mbe_in_if.sink                               in_ch,
	mbe_out_if.source                            out_ch
);
	import mbe_pkg::*;

	state_t                           state_q, state_d;
	dp_ctrl_t                         ctrl;
	logic                             escape;
	logic                             in_accept;
	logic                             out_free;
	logic [LIMIT_WIDTH-1:0]           limit_q;
	logic [COUNT_WIDTH+LIMIT_WIDTH-1:0] limit_ext;
	logic [COUNT_WIDTH-1:0]           limit_eff;
	logic [COUNT_WIDTH-1:0]           run_limit_q;
	logic [COUNT_WIDTH-1:0]           count_q;
	logic [COUNT_WIDTH+COUNT_OUT_WIDTH-1:0] count_ext;
	logic                             at_limit;
	logic                             hit_q;
	logic                             out_valid_q;
	logic [COUNT_OUT_WIDTH-1:0]       out_count_q;
	logic                             out_reached_q;

	assign in_accept = in_ch.valid && in_ch.ready;
	assign out_free  = !out_valid_q || out_ch.ready;
	assign at_limit  = count_q == run_limit_q;

	// Mask the limit to the counter width
	assign limit_ext = {{COUNT_WIDTH{1'b0}}, limit_q};
	assign limit_eff = limit_ext[COUNT_WIDTH-1:0];
	assign count_ext = {{COUNT_OUT_WIDTH{1'b0}}, count_q};

	// Hold the limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= DEF_ITER_LIMIT;
		end else if (limit_we) begin
			limit_q <= limit_wdata;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_accept) state_d = S_MUL_RE;
			end
			S_MUL_RE: begin
				state_d = at_limit ? S_DONE : S_MUL_IM;
			end
			S_MUL_IM: begin
				state_d = S_MUL_X;
			end
			S_MUL_X: begin
				state_d = escape ? S_DONE : S_UPDATE;
			end
			S_UPDATE: begin
				state_d = S_MUL_RE;
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		ctrl.start   = in_accept;
		ctrl.mul_sel = MUL_RR;
		ctrl.cap_sr  = 1'b0;
		ctrl.cap_si  = 1'b0;
		ctrl.update  = 1'b0;
		in_ch.ready  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ch.ready = 1'b1;
			end
			S_MUL_RE: begin
				ctrl.mul_sel = MUL_RR;
			end
			S_MUL_IM: begin
				ctrl.mul_sel = MUL_II;
				ctrl.cap_sr  = 1'b1;
			end
			S_MUL_X: begin
				ctrl.mul_sel = MUL_RI;
				ctrl.cap_si  = 1'b1;
			end
			S_UPDATE: begin
				ctrl.update = 1'b1;
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Advance state, iteration count and exit flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			run_limit_q <= '0;
			hit_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_accept) begin
				count_q     <= '0;
				run_limit_q <= limit_eff;
			end else if (state_q == S_UPDATE) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == S_MUL_RE && at_limit) begin
				hit_q <= 1'b1;
			end else if (state_q == S_MUL_X && escape) begin
				hit_q <= 1'b0;
			end
		end
	end

	// Output register: load on finish, drop on take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_count_q   <= count_ext[COUNT_OUT_WIDTH-1:0];
			out_reached_q <= hit_q;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.iteration_count = out_count_q;
	assign out_ch.reached_limit   = out_reached_q;

	mbe_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk    (clk),
		.ctrl   (ctrl),
		.c_real (in_ch.c_real),
		.c_imag (in_ch.c_imag),
		.escape (escape)
	);

	// Checks
	`MBE_ASSERT_NEXT(a_accept_starts, clk, arst_n, in_accept, state_q == S_MUL_RE, "accepted point did not start")
	`MBE_ASSERT_SAME(a_count_bounded, clk, arst_n, state_q != S_IDLE, count_q <= run_limit_q, "iteration count passed the limit")
	`MBE_ASSERT_NEXT(a_done_posts, clk, arst_n, state_q == S_DONE && !out_valid_q, out_valid_q && state_q == S_IDLE, "finished point not posted")

endmodule
